// File: hdl/nskh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nskh_pkg
// Shared constants, types and the FNV-1a fold for the name/size key hash.
// ----------------------------------------------------------------------------
package nskh_pkg;

   localparam int unsigned HashWidth  = 32;
   localparam int unsigned ByteWidth  = 8;
   localparam int unsigned SizeWidth  = 32;
   localparam int unsigned DigitsMax  = 10;
   localparam int unsigned CountWidth = 4;

   localparam logic [HashWidth-1:0] HASH_BASIS = 32'd2166136261;
   localparam logic [ByteWidth-1:0] CHAR_COLON = 8'h3a;
   localparam logic [ByteWidth-1:0] CHAR_ZERO  = 8'h30;
   // ceil(2^35 / 10), exact quotient for any 32-bit dividend
   localparam logic [SizeWidth-1:0] RECIP_TEN  = 32'hcccccccd;
   localparam int unsigned          RecipShift = 35;

   typedef struct packed {
      logic load_byte;
      logic load_size;
      logic fold_colon;
      logic div_step;
      logic fold_digit;
      logic emit;
   } nskh_cmd_type;

   typedef struct packed {
      logic quot_zero;
      logic last_digit;
   } nskh_status_type;

   // xor the byte, then multiply by 16777619 = 2^24 + 2^8 + 2^7 + 2^4 + 2^1 + 1
   function automatic logic [HashWidth-1:0] fnv_fold(input logic [HashWidth-1:0] h,
                                                      input logic [ByteWidth-1:0] b);
      logic [HashWidth-1:0] x;
      x = h ^ {{(HashWidth-ByteWidth){1'b0}}, b};
      return (x << 24) + (x << 8) + (x << 7) + (x << 4) + (x << 1) + x;
   endfunction

endpackage

// File: hdl/nskh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nskh_req_if / nskh_rsp_if
// Valid/ready channels carrying name bytes in and key hashes out.
// ----------------------------------------------------------------------------
interface nskh_req_if;
   logic        valid;
   logic        ready;
   logic [7:0]  name_byte;
   logic        is_last;
   logic [31:0] file_len;

   modport source (output valid, output name_byte, output is_last, output file_len,
                   input ready);
   modport sink   (input valid, input name_byte, input is_last, input file_len,
                   output ready);
endinterface

interface nskh_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] key_hash;

   modport source (output valid, output key_hash, input ready);
   modport sink   (input valid, input key_hash, output ready);
endinterface

// File: hdl/name_size_key_hash.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// name_size_key_hash
// FNV-1a key over a name, a colon and the decimal file size.
// ----------------------------------------------------------------------------
//  channel   dir   handshake        payload
//  req_if    in    valid / ready    name_byte[7:0], is_last, file_len[31:0]
//  rsp_if    out   valid / ready    key_hash[31:0]
//
//  an item not marked last is folded and ready stays high
//  a last item is folded too, then a colon and a size of D decimal digits (D = 1..10):
//  each digit comes out of the reciprocal divide-by-ten, then each digit is folded
//  the result sits in an output register; new items are taken while it waits,
//  but the last fold of the next key stalls until the previous result is taken
//  synchronous active-high reset loads the offset basis and empties the output
// ----------------------------------------------------------------------------
module name_size_key_hash (
   input  logic        clock,
   input  logic        reset,
   nskh_req_if.sink    req_if,
   nskh_rsp_if.source  rsp_if
);
   import nskh_pkg::*;

   nskh_cmd_type    cmd;
   nskh_status_type status;

   nskh_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_is_last (req_if.is_last),
      .req_ready   (req_if.ready),
      .rsp_ready   (rsp_if.ready),
      .rsp_valid   (rsp_if.valid),
      .status      (status),
      .cmd         (cmd)
   );

   nskh_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .name_byte (req_if.name_byte),
      .file_len  (req_if.file_len),
      .key_hash  (rsp_if.key_hash)
   );

endmodule

// File: hdl/nskh_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nskh_ctrl
// Sequencer for byte folding, the size-to-decimal loop and result hand-off.
// ----------------------------------------------------------------------------
module nskh_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_is_last,
   output logic                     req_ready,
   input  logic                     rsp_ready,
   output logic                     rsp_valid,
   input  nskh_pkg::nskh_status_type status,
   output nskh_pkg::nskh_cmd_type    cmd
);
   import nskh_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_COLON = 4'b0010,
      ST_DIV   = 4'b0100,
      ST_FOLD  = 4'b1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_byte = 1'b1;
               if (req_is_last) begin
                  cmd.load_size = 1'b1;
                  state_in      = ST_COLON;
               end
            end
         end
         ST_COLON: begin
            cmd.fold_colon = 1'b1;
            cmd.div_step   = 1'b1;
            state_in       = status.quot_zero ? ST_FOLD : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.quot_zero) begin
               state_in = ST_FOLD;
            end
         end
         ST_FOLD: begin
            if (!status.last_digit) begin
               cmd.fold_digit = 1'b1;
            end else if (out_free) begin
               cmd.fold_digit = 1'b1;
               cmd.emit       = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/nskh_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nskh_datapath
// Running hash, divide-by-ten digit extraction, digit store and result register.
// ----------------------------------------------------------------------------
module nskh_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  nskh_pkg::nskh_cmd_type    cmd,
   output nskh_pkg::nskh_status_type status,
   input  logic [7:0]               name_byte,
   input  logic [31:0]              file_len,
   output logic [31:0]              key_hash
);
   import nskh_pkg::*;

   logic [HashWidth-1:0]    hash_ff, hash_in;
   logic [HashWidth-1:0]    out_ff;
   logic [SizeWidth-1:0]    size_ff;
   logic [CountWidth-1:0]   count_ff, count_in;
   logic [3:0]              digit_ff [DigitsMax];
   logic [2*SizeWidth-1:0]  product;
   logic [SizeWidth-1:0]    quot;
   logic [3:0]              tens_low;
   logic [3:0]              rem;
   logic [CountWidth-1:0]   rd_index;
   logic [ByteWidth-1:0]    digit_char;
   logic [HashWidth-1:0]    digit_fold;

   // quotient by reciprocal multiply, remainder from the low nibble
   assign product  = size_ff * RECIP_TEN;
   assign quot     = SizeWidth'(product >> RecipShift);
   assign tens_low = 4'(({quot[0 +: 4], 3'b000}) + ({quot[0 +: 4], 1'b0}));
   assign rem      = size_ff[3:0] - tens_low;

   assign rd_index   = count_ff - CountWidth'(1);
   assign digit_char = CHAR_ZERO | {4'b0000, digit_ff[rd_index]};
   assign digit_fold = fnv_fold(hash_ff, digit_char);

   assign status.quot_zero  = (quot == '0);
   assign status.last_digit = (count_ff == CountWidth'(1));
   assign key_hash          = out_ff;

   always_comb begin
      hash_in = hash_ff;
      if (cmd.load_byte) begin
         hash_in = fnv_fold(hash_ff, name_byte);
      end else if (cmd.fold_colon) begin
         hash_in = fnv_fold(hash_ff, CHAR_COLON);
      end else if (cmd.emit) begin
         hash_in = HASH_BASIS;
      end else if (cmd.fold_digit) begin
         hash_in = digit_fold;
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.load_size) begin
         count_in = '0;
      end else if (cmd.div_step) begin
         count_in = count_ff + CountWidth'(1);
      end else if (cmd.fold_digit) begin
         count_in = rd_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hash_ff  <= HASH_BASIS;
         count_ff <= '0;
      end else begin
         hash_ff  <= hash_in;
         count_ff <= count_in;
      end
   end

   // least significant digit lands at index 0, read back from the top down
   always_ff @(posedge clock) begin
      if (cmd.load_size) begin
         size_ff <= file_len;
      end else if (cmd.div_step) begin
         size_ff <= quot;
      end
      if (cmd.div_step) begin
         digit_ff[count_ff] <= rem;
      end
      if (cmd.emit) begin
         out_ff <= digit_fold;
      end
   end

endmodule

// File: hdl/nskh_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nskh_check
// Port-level checks on the key hash block, bound to the top level.
// ----------------------------------------------------------------------------
module nskh_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_is_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_key_hash
);

   // a result waiting is held
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp item dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_key_hash))
      else $error("rsp key_hash changed while stalled");

   // the size tail blocks new items
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_is_last |=> !req_ready)
      else $error("item taken during size tail");

   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_is_last |=> req_ready)
      else $error("ready lost after plain name byte");

   // a new result only comes out of the size tail
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result without size tail");

endmodule

bind name_size_key_hash nskh_check u_check (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .req_is_last  (req_if.is_last),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_key_hash (rsp_if.key_hash)
);
